// File: rtl/quaternion_multiply_normalize_assert.svh
// Assertion helpers for the quaternion product block
`ifndef QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define QMN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("quaternion_multiply_normalize: assertion failed");

// next-cycle implication
`define QMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("quaternion_multiply_normalize: assertion failed");

`endif

// File: rtl/qmn_pkg.sv
`default_nettype none
package qmn_pkg;
	localparam int DEF_FRAC_BITS = 30;
	localparam int DATA_W = 32;
	localparam int FLOOR_W = 31;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 31'd1;
	localparam int ROOT_W = 64;
	localparam int SUMSQ_W = 2 * ROOT_W;
	localparam int MAG_W = 63;
	localparam int NUM_PARTS = 4;

	typedef logic signed [DATA_W-1:0] part_t;
	typedef logic [MAG_W-1:0] mag_t;
endpackage
`default_nettype wire

// File: rtl/qmn_sqrt.sv
`default_nettype none
module qmn_sqrt import qmn_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               en,
	input  logic [SUMSQ_W-1:0] sum_sq,
	input  logic [SIDE_W-1:0]  side_i,
	output logic [ROOT_W-1:0]  root_o,
	output logic [SIDE_W-1:0]  side_o
);
	localparam int RW = ROOT_W + 3;

	// one root bit per stage, radicand consumed two bits at a time
	logic [RW-1:0]      rem_s  [ROOT_W];
	logic [ROOT_W-1:0]  root_s [ROOT_W];
	logic [SUMSQ_W-1:0] rad_s  [ROOT_W];
	logic [SIDE_W-1:0]  side_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [RW-1:0]      rem_prev, rem_sh, trial, rem_next;
		logic [ROOT_W-1:0]  root_prev;
		logic [SUMSQ_W-1:0] rad_prev;
		logic [SIDE_W-1:0]  side_prev;
		logic               ge;

		if (i == 0) begin : g_first
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign rad_prev  = sum_sq;
			assign side_prev = side_i;
		end else begin : g_next
			assign rem_prev  = rem_s[i-1];
			assign root_prev = root_s[i-1];
			assign rad_prev  = rad_s[i-1];
			assign side_prev = side_s[i-1];
		end

		assign rem_sh   = {rem_prev[RW-3:0], rad_prev[SUMSQ_W-1 -: 2]};
		assign trial    = {1'b0, root_prev, 2'b01};
		assign ge       = rem_sh >= trial;
		assign rem_next = ge ? rem_sh - trial : rem_sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= rem_next;
				root_s[i] <= {root_prev[ROOT_W-2:0], ge};
				rad_s[i]  <= rad_prev << 2;
				side_s[i] <= side_prev;
			end
		end
	end

	assign root_o = root_s[ROOT_W-1];
	assign side_o = side_s[ROOT_W-1];
endmodule
`default_nettype wire

// File: rtl/qmn_div.sv
`default_nettype none
module qmn_div import qmn_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int SIDE_W    = 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  mag_t                  num_i [NUM_PARTS],
	input  logic [ROOT_W-1:0]     den_i,
	input  logic [SIDE_W-1:0]     side_i,
	output logic [FRAC_BITS+1:0]  mag_o [NUM_PARTS],
	output logic [SIDE_W-1:0]     side_o
);
	localparam int STG = FRAC_BITS + 1;
	localparam int QW  = FRAC_BITS + 1;
	localparam int OW  = FRAC_BITS + 2;

	// first stage yields the integer bit (num >= den), the rest one fraction bit each
	logic [ROOT_W-1:0] rem_s  [STG][NUM_PARTS];
	logic [QW-1:0]     quo_s  [STG][NUM_PARTS];
	logic [ROOT_W-1:0] den_s  [STG];
	logic [SIDE_W-1:0] side_s [STG];

	for (genvar i = 0; i < STG; i++) begin : g_stage
		logic [ROOT_W-1:0] den_prev;
		logic [SIDE_W-1:0] side_prev;

		if (i == 0) begin : g_first
			assign den_prev  = den_i;
			assign side_prev = side_i;
		end else begin : g_next
			assign den_prev  = den_s[i-1];
			assign side_prev = side_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i]  <= den_prev;
				side_s[i] <= side_prev;
			end
		end

		for (genvar l = 0; l < NUM_PARTS; l++) begin : g_lane
			logic [ROOT_W:0]   rem_sh, diff;
			logic [QW-1:0]     quo_prev;
			logic              ge;

			if (i == 0) begin : g_first
				assign rem_sh   = {2'b00, num_i[l]};
				assign quo_prev = '0;
			end else begin : g_next
				assign rem_sh   = {rem_s[i-1][l], 1'b0};
				assign quo_prev = quo_s[i-1][l];
			end

			assign diff = rem_sh - {1'b0, den_prev};
			assign ge   = rem_sh >= {1'b0, den_prev};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i][l] <= ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
					quo_s[i][l] <= {quo_prev[QW-2:0], ge};
				end
			end
		end
	end

	// round half up: 2*rem >= den
	for (genvar l = 0; l < NUM_PARTS; l++) begin : g_round
		logic rnd;
		assign rnd      = {rem_s[STG-1][l], 1'b0} >= {1'b0, den_s[STG-1]};
		assign mag_o[l] = {1'b0, quo_s[STG-1][l]} + OW'(rnd);
	end

	assign side_o = side_s[STG-1];
endmodule
`default_nettype wire

// File: rtl/quaternion_multiply_normalize.sv
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Depth is set by the 64-stage square root and the FRAC_BITS + 1 stage divider lanes.
// Reset clears all valid bits and sets the stored floor (floor_q) to 1; no clearing pass.
`default_nettype none
`include "quaternion_multiply_normalize_assert.svh"
module quaternion_multiply_normalize import qmn_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  part_t              a_w,
	input  part_t              a_x,
	input  part_t              a_y,
	input  part_t              a_z,
	input  part_t              b_w,
	input  part_t              b_x,
	input  part_t              b_y,
	input  part_t              b_z,
	output logic               out_valid,
	input  logic               out_stall,
	output part_t              r_w,
	output part_t              r_x,
	output part_t              r_y,
	output part_t              r_z,
	output logic               zero_magnitude,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FLOOR_W-1:0] magnitude_floor
);
	localparam int PW      = 2 * DATA_W;
	localparam int SW      = PW + 2;
	localparam int DIV_LAT = FRAC_BITS + 1;
	localparam int LAT     = 6 + ROOT_W + DIV_LAT + 1;
	localparam int SH      = FRAC_BITS - 2;
	localparam int OW      = FRAC_BITS + 2;
	localparam int CW      = (OW > DATA_W + 1) ? OW : DATA_W + 1;
	localparam int SQ_SIDE = NUM_PARTS * (MAG_W + 1);
	localparam int DV_SIDE = NUM_PARTS + 1;
	localparam logic [CW-1:0] POS_MAX = CW'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic [CW-1:0] NEG_MAX = CW'({1'b1, {(DATA_W-1){1'b0}}});

	logic [FLOOR_W-1:0] floor_q;
	logic [LAT-1:0]     vld_q;
	logic               adv;

	assign cfg_ready = 1'b1;
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			floor_q <= magnitude_floor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: sixteen products
	part_t a_v [NUM_PARTS];
	part_t b_v [NUM_PARTS];
	logic signed [PW-1:0] prod_s1 [NUM_PARTS][NUM_PARTS];

	assign a_v = '{a_w, a_x, a_y, a_z};
	assign b_v = '{b_w, b_x, b_y, b_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				for (int j = 0; j < NUM_PARTS; j++) begin
					prod_s1[i][j] <= a_v[i] * b_v[j];
				end
			end
		end
	end

	// stage 2: Hamilton sums, floor divide by 4
	logic signed [SW-1:0] ham [NUM_PARTS];
	logic signed [PW-1:0] q_s2 [NUM_PARTS];

	assign ham[0] = SW'(prod_s1[0][0]) - SW'(prod_s1[1][1]) - SW'(prod_s1[2][2])
		- SW'(prod_s1[3][3]);
	assign ham[1] = SW'(prod_s1[0][1]) + SW'(prod_s1[1][0]) + SW'(prod_s1[2][3])
		- SW'(prod_s1[3][2]);
	assign ham[2] = SW'(prod_s1[0][2]) - SW'(prod_s1[1][3]) + SW'(prod_s1[2][0])
		+ SW'(prod_s1[3][1]);
	assign ham[3] = SW'(prod_s1[0][3]) + SW'(prod_s1[1][2]) - SW'(prod_s1[2][1])
		+ SW'(prod_s1[3][0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_PARTS; c++) begin
				q_s2[c] <= ham[c][SW-1:2];
			end
		end
	end

	// stage 3: sign and magnitude
	mag_t u_s3 [NUM_PARTS];
	logic neg_s3 [NUM_PARTS];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_PARTS; c++) begin
				neg_s3[c] <= q_s2[c][PW-1];
				u_s3[c]   <= q_s2[c][PW-1] ? MAG_W'(-q_s2[c]) : MAG_W'(q_s2[c]);
			end
		end
	end

	// stage 4: partial products of the squares
	logic [61:0] hh_s4 [NUM_PARTS];
	logic [62:0] hl_s4 [NUM_PARTS];
	logic [63:0] ll_s4 [NUM_PARTS];
	mag_t u_s4 [NUM_PARTS];
	logic neg_s4 [NUM_PARTS];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_PARTS; c++) begin
				hh_s4[c]  <= u_s3[c][62:32] * u_s3[c][62:32];
				hl_s4[c]  <= u_s3[c][62:32] * u_s3[c][31:0];
				ll_s4[c]  <= u_s3[c][31:0] * u_s3[c][31:0];
				u_s4[c]   <= u_s3[c];
				neg_s4[c] <= neg_s3[c];
			end
		end
	end

	// stage 5: squares, stage 6: sum of squares
	logic [SUMSQ_W-1:0] sq_s5 [NUM_PARTS];
	logic [SUMSQ_W-1:0] sum_s6;
	mag_t u_s5 [NUM_PARTS];
	mag_t u_s6 [NUM_PARTS];
	logic neg_s5 [NUM_PARTS];
	logic neg_s6 [NUM_PARTS];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_PARTS; c++) begin
				sq_s5[c]  <= (SUMSQ_W'(hh_s4[c]) << 64) + (SUMSQ_W'(hl_s4[c]) << 33)
					+ SUMSQ_W'(ll_s4[c]);
				u_s5[c]   <= u_s4[c];
				neg_s5[c] <= neg_s4[c];
				u_s6[c]   <= u_s5[c];
				neg_s6[c] <= neg_s5[c];
			end
			sum_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2] + sq_s5[3];
		end
	end

	// square root, sign and magnitude ride alongside
	logic [SQ_SIDE-1:0] sq_side_in, sq_side_out;
	logic [ROOT_W-1:0]  root;
	mag_t               u_r   [NUM_PARTS];
	logic               neg_r [NUM_PARTS];

	always_comb begin
		for (int c = 0; c < NUM_PARTS; c++) begin
			sq_side_in[c*(MAG_W+1) +: MAG_W+1] = {neg_s6[c], u_s6[c]};
			u_r[c]   = sq_side_out[c*(MAG_W+1) +: MAG_W];
			neg_r[c] = sq_side_out[c*(MAG_W+1) + MAG_W];
		end
	end

	qmn_sqrt #(
		.SIDE_W (SQ_SIDE)
	) u_sqrt (
		.clk    (clk),
		.en     (adv),
		.sum_sq (sum_s6),
		.side_i (sq_side_in),
		.root_o (root),
		.side_o (sq_side_out)
	);

	// root <= floor * 2^SH  <=>  ceil(root / 2^SH) <= floor
	logic [ROOT_W:0] ceil_hi;
	logic            below_floor;

	assign ceil_hi     = {1'b0, ROOT_W'(root >> SH)} + (ROOT_W+1)'(|root[SH-1:0]);
	assign below_floor = ceil_hi <= (ROOT_W+1)'(floor_q);

	logic [DV_SIDE-1:0] dv_side_in, dv_side_out;
	logic [OW-1:0]      mag [NUM_PARTS];

	assign dv_side_in = {below_floor, neg_r[3], neg_r[2], neg_r[1], neg_r[0]};

	qmn_div #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (DV_SIDE)
	) u_div (
		.clk    (clk),
		.en     (adv),
		.num_i  (u_r),
		.den_i  (root),
		.side_i (dv_side_in),
		.mag_o  (mag),
		.side_o (dv_side_out)
	);

	// output stage: sign, saturation, zero forcing
	part_t         res [NUM_PARTS];
	part_t         r_q [NUM_PARTS];
	logic          zero_q;
	logic [CW-1:0] magx [NUM_PARTS];

	always_comb begin
		for (int c = 0; c < NUM_PARTS; c++) begin
			magx[c] = CW'(mag[c]);
			if (dv_side_out[c]) begin
				res[c] = (magx[c] > NEG_MAX) ? part_t'(NEG_MAX) : part_t'(-magx[c]);
			end else begin
				res[c] = (magx[c] > POS_MAX) ? part_t'(POS_MAX) : part_t'(magx[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < NUM_PARTS; c++) begin
				r_q[c] <= dv_side_out[NUM_PARTS] ? '0 : res[c];
			end
			zero_q <= dv_side_out[NUM_PARTS];
		end
	end

	assign r_w            = r_q[0];
	assign r_x            = r_q[1];
	assign r_y            = r_q[2];
	assign r_z            = r_q[3];
	assign zero_magnitude = zero_q;

	`QMN_ASSERT_IMPLY(zero_result_clear, clk, arst_n, out_valid && zero_magnitude,
		r_w == 0 && r_x == 0 && r_y == 0 && r_z == 0)
	`QMN_ASSERT_IMPLY(unit_result_nonzero, clk, arst_n, out_valid && !zero_magnitude,
		r_w != 0 || r_x != 0 || r_y != 0 || r_z != 0)
	`QMN_ASSERT_IMPLY(stall_reaches_input, clk, arst_n, out_valid && out_stall, in_stall)
	`QMN_ASSERT_NEXT(floor_takes_write, clk, arst_n, cfg_valid && cfg_ready,
		floor_q == $past(magnitude_floor))
endmodule
`default_nettype wire
